// ===== src/cbm_pkg.sv =====
// Types and constants shared by the bank mapper.
package cbm_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FETCH = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2,
    TGT_CHR  = 2'd3
  } tgt_e;

  typedef enum logic [1:0] {
    FETCH_BG     = 2'd0,
    FETCH_SPRITE = 2'd1,
    FETCH_PORT   = 2'd2
  } fetch_e;

  localparam logic [1:0] CFG_PRG_ROM_MASK = 2'd0;
  localparam logic [1:0] CFG_PRG_RAM_MASK = 2'd1;
  localparam logic [1:0] CFG_CHR_MASK     = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  bus_value;
    logic [1:0]  fetch_kind;
    logic        tall_sprites;
    logic        frame_active;
    logic        line_done;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] mem_address;
    logic        mem_write;
    logic [7:0]  read_data;
    logic        irq;
  } out_item_t;

endpackage

// ===== src/cartridge_bank_mapper_with_scanline_irq_unit.sv =====
// Bank mapper top level: address translation, registers, scanline IRQ, extension RAM.
//
// Channels: in_* carries one bus event (CPU read, CPU write, pattern fetch or
// PPU tick); out_* returns exactly one result per event in arrival order;
// cfg_* writes the three size masks (index 0 ROM, 1 RAM, 2 pattern).
// An event is decoded and all state is updated in the cycle it transfers in;
// its result sits in the output register from the next cycle on. Extension
// RAM reads are a registered memory read launched in the same cycle, so they
// add no delay.
// Throughput is one event per cycle once the clearing pass is done: in_ready_o
// is high whenever the output register is empty or is being emptied in the same
// cycle. If the receiver stalls, the result holds and input is refused until it drains.
// Reset restores the power-on bank setup (last 8 KB bank mapped at the top,
// masks at their defaults) and clears the IRQ logic. After reset a clearing
// pass writes zero to every extension RAM entry, one per cycle, so in_ready_o
// stays low until all EXRAM_DEPTH (1024) entries are cleared.
module cartridge_bank_mapper_with_scanline_irq_unit
  import cbm_pkg::*;
#(
  parameter int EXRAM_DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i
);

  localparam int AW = $clog2(EXRAM_DEPTH);

  logic [19:0] rom_mask_q;
  logic [15:0] ram_mask_q;
  logic [20:0] chr_mask_q;
  logic [1:0]  prg_mode_q, chr_mode_q, exram_mode_q;
  logic [2:0]  low_bank_q;
  logic [7:0]  prg_bank_q [4];
  logic [7:0]  chr_bank_q [12];
  logic        upper_last_q;
  logic [7:0]  mul_l_q, mul_r_q, irq_tgt_q, line_cnt_q;
  logic        irq_en_q, in_frame_q, pend_q, irq_q;

  logic [7:0]  exram [EXRAM_DEPTH];
  logic [7:0]  ex_rd_q;
  logic        ex_sel_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_idx_q;

  out_item_t   res_q, res_d;
  logic        ovalid_q;

  logic        acc;
  in_item_t    it;
  logic [15:0] a;
  logic        is_rd, is_wr, lo_ram, hi_sp, regs51, regs52, exr;
  logic [AW-1:0] ex_a;
  logic [15:0] prod;

  assign it = in_data_i;
  assign a  = it.address;
  assign in_ready_o  = !clr_busy_q && (!ovalid_q || out_ready_i);
  assign acc         = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;
  assign is_rd  = (it.command == CMD_READ);
  assign is_wr  = (it.command == CMD_WRITE);
  assign lo_ram = (a[15:13] == 3'b011);
  assign hi_sp  = a[15];
  assign regs51 = (a >= 16'h5100) && (a < 16'h512C);
  assign regs52 = (a >= 16'h5200) && (a < 16'h5207);
  assign exr    = (a[15:10] == 6'b010111);
  assign ex_a   = a[AW-1:0];
  assign prod   = mul_l_q * mul_r_q;

  // program window translation
  logic [1:0]  p_tgt;
  logic [20:0] p_addr;
  always_comb begin
    logic [6:0]  bk;
    logic [14:0] off;
    logic [7:0]  b;
    logic        clr;
    logic [21:0] sum;
    logic [15:0] rsum;
    bk = '0; off = '0; b = '0; clr = 1'b0; sum = '0; rsum = '0;
    p_tgt = TGT_ROM;
    if (prg_mode_q == 2'd0) begin
      bk = prg_bank_q[3][6:0] & 7'h7C; off = a[14:0];
    end else if (prg_mode_q == 2'd1 && a[14]) begin
      bk = prg_bank_q[3][6:0] & 7'h7E; off = {1'b0, a[13:0]};
    end else if (a[14:13] == 2'b11) begin
      bk = prg_bank_q[3][6:0]; off = {2'b0, a[12:0]};
    end else begin
      if (prg_mode_q != 2'd3 && !a[14]) begin
        b = prg_bank_q[1]; clr = 1'b1; off = {1'b0, a[13:0]};
      end else begin
        b = prg_bank_q[a[14:13]]; off = {2'b0, a[12:0]};
      end
      if (b[7]) bk = b[6:0] & ~{6'b0, clr};
      else p_tgt = TGT_RAM;
    end
    sum  = {bk, 13'b0} + {7'b0, off};
    rsum = {b[1:0] & ~{1'b0, clr}, 13'b0} + {1'b0, off};
    if (p_tgt == TGT_ROM) p_addr = {1'b0, sum[19:0] & rom_mask_q};
    else p_addr = {5'b0, (rsum & ram_mask_q) | {b[2], 15'b0}};
  end

  logic [20:0] lo_addr;
  always_comb begin
    logic [15:0] s;
    s = {1'b0, low_bank_q[1:0], a[12:0]};
    lo_addr = {5'b0, (s & ram_mask_q) | {low_bank_q[2], 15'b0}};
  end

  // pattern translation
  logic [20:0] c_addr;
  always_comb begin
    logic [2:0]  w;
    logic [3:0]  r;
    logic        up;
    logic [20:0] s;
    up = it.tall_sprites && (it.fetch_kind == FETCH_BG ||
         (it.fetch_kind == FETCH_PORT && upper_last_q));
    case (chr_mode_q)
      2'd0: w = 3'd0;
      2'd1: w = {2'b0, a[12]};
      2'd2: w = {1'b0, a[12:11]};
      default: w = a[12:10];
    endcase
    if (!up) begin
      case (chr_mode_q)
        2'd0: r = 4'd7;
        2'd1: r = {1'b0, w[0], 2'b11};
        2'd2: r = {1'b0, w[1:0], 1'b1};
        default: r = {1'b0, w};
      endcase
    end else begin
      case (chr_mode_q)
        2'd3: r = {2'b10, w[1:0]};
        2'd2: r = w[0] ? 4'd11 : 4'd9;
        default: r = 4'd11;
      endcase
    end
    case (chr_mode_q)
      2'd0: s = {chr_bank_q[r], a[12:0]};
      2'd1: s = {1'b0, chr_bank_q[r], a[11:0]};
      2'd2: s = {2'b0, chr_bank_q[r], a[10:0]};
      default: s = {3'b0, chr_bank_q[r], a[9:0]};
    endcase
    c_addr = s & chr_mask_q;
  end

  // tick update of the scanline logic, then status read clears
  logic [7:0] lc_d;
  logic       inf_d, pend_d, irq_d;
  always_comb begin
    logic [7:0] nx;
    nx = line_cnt_q + 8'd1;
    lc_d = line_cnt_q; inf_d = in_frame_q; pend_d = pend_q; irq_d = irq_q;
    if (acc && it.command == CMD_TICK) begin
      if (it.frame_active) begin
        if (it.line_done) begin
          if (!in_frame_q) begin
            inf_d = 1'b1; lc_d = '0; pend_d = 1'b0;
          end else begin
            lc_d = nx;
            if (nx == irq_tgt_q) pend_d = 1'b1;
          end
        end
      end else begin
        inf_d = 1'b0;
      end
      if (pend_d && irq_en_q) irq_d = 1'b1;
    end
    if (acc && is_rd && !hi_sp && !lo_ram && regs52 && a[2:0] == 3'd4) begin
      pend_d = 1'b0; irq_d = 1'b0;
    end
  end

  // result, read_data for register reads; extension RAM byte merged at output
  logic ex_sel_d;
  always_comb begin
    res_d = '0;
    ex_sel_d = 1'b0;
    res_d.irq = irq_d;
    case (it.command)
      CMD_READ, CMD_WRITE: begin
        if (lo_ram) begin
          res_d.target = TGT_RAM; res_d.mem_address = lo_addr; res_d.mem_write = is_wr;
        end else if (hi_sp) begin
          if (is_rd || p_tgt == TGT_RAM) begin
            res_d.target = p_tgt; res_d.mem_address = p_addr; res_d.mem_write = is_wr;
          end
        end else if (is_rd) begin
          res_d.read_data = it.bus_value;
          if (regs52) begin
            case (a[2:0])
              3'd3: res_d.read_data = irq_tgt_q;
              3'd4: res_d.read_data = {pend_q, in_frame_q, 6'b0};
              3'd5: res_d.read_data = prod[7:0];
              3'd6: res_d.read_data = prod[15:8];
              default: res_d.read_data = it.bus_value;
            endcase
          end else if (exr && exram_mode_q[1]) begin
            ex_sel_d = 1'b1;
          end
        end
      end
      CMD_FETCH: begin
        res_d.target = TGT_CHR; res_d.mem_address = c_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) exram[clr_idx_q] <= 8'h00;
    else if (acc && is_wr && exr) exram[ex_a] <= it.write_data;
    if (acc) ex_rd_q <= exram[ex_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_mask_q <= 20'hFFFFF; ram_mask_q <= 16'h7FFF; chr_mask_q <= 21'h1FFF;
      prg_mode_q <= 2'd3; chr_mode_q <= 2'd3; exram_mode_q <= '0; low_bank_q <= '0;
      prg_bank_q <= '{8'h00, 8'h00, 8'h00, 8'hFF};
      for (int i = 0; i < 12; i++) chr_bank_q[i] <= '0;
      upper_last_q <= 1'b0; mul_l_q <= '0; mul_r_q <= '0; irq_tgt_q <= '0;
      irq_en_q <= 1'b0; line_cnt_q <= '0; in_frame_q <= 1'b0; pend_q <= 1'b0;
      irq_q <= 1'b0; ex_sel_q <= 1'b0;
      clr_busy_q <= 1'b1; clr_idx_q <= '0;
      ovalid_q <= 1'b0; res_q <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (&clr_idx_q) clr_busy_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_PRG_ROM_MASK: rom_mask_q <= cfg_data_i[19:0];
          CFG_PRG_RAM_MASK: ram_mask_q <= cfg_data_i[15:0];
          CFG_CHR_MASK:     chr_mask_q <= cfg_data_i;
          default: ;
        endcase
      end
      line_cnt_q <= lc_d; in_frame_q <= inf_d; pend_q <= pend_d; irq_q <= irq_d;
      if (acc && is_wr && !hi_sp && !lo_ram) begin
        if (regs51) begin
          case (a[5:0])
            6'h00: prg_mode_q <= it.write_data[1:0];
            6'h01: chr_mode_q <= it.write_data[1:0];
            6'h04: exram_mode_q <= it.write_data[1:0];
            6'h13: low_bank_q <= it.write_data[2:0];
            6'h14, 6'h15, 6'h16, 6'h17: prg_bank_q[a[1:0]] <= it.write_data;
            default: begin
              if (a[5:4] == 2'b10) begin
                chr_bank_q[a[3:0]] <= it.write_data;
                upper_last_q <= (a[3:0] >= 4'd8);
              end
            end
          endcase
        end else if (regs52) begin
          case (a[2:0])
            3'd3: irq_tgt_q <= it.write_data;
            3'd4: irq_en_q <= it.write_data[7];
            3'd5: mul_l_q <= it.write_data;
            3'd6: mul_r_q <= it.write_data;
            default: ;
          endcase
        end
      end
      if (acc) begin
        res_q <= res_d;
        ex_sel_q <= ex_sel_d;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    out_data_o = res_q;
    if (ex_sel_q) out_data_o.read_data = ex_rd_q;
  end

  a_irq_needs_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!irq_q && irq_d) |-> pend_d) else $error("irq raised without pending");
  a_tgt_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.target == TGT_NONE) |-> out_data_o.mem_address == '0)
    else $error("address on no-access result");
  a_write_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.mem_write) |-> out_data_o.target == TGT_RAM)
    else $error("write flag off RAM");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(res_q)) else $error("result lost");

endmodule

// ===== bench/tb_cartridge_bank_mapper_with_scanline_irq_unit.sv =====
// Self-checking testbench for the bank mapper: directed table, then random bus traffic.
`timescale 1ns / 100ps

module tb_cartridge_bank_mapper_with_scanline_irq_unit;
  import cbm_pkg::*;

  localparam int          HALF_PERIOD  = 10;
  localparam int          IDLE_LIMIT   = 5000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          N_PHASES     = 5;
  localparam int          PHASE_ITEMS  = 305;
  localparam int          IN_W         = $bits(in_item_t);
  localparam logic [15:0] A_PRG_MODE   = 16'h5100;
  localparam logic [15:0] A_CHR_MODE   = 16'h5101;
  localparam logic [15:0] A_EXRAM_MODE = 16'h5104;
  localparam logic [15:0] A_LOW_BANK   = 16'h5113;
  localparam logic [15:0] A_PRG_BANK0  = 16'h5114;
  localparam logic [15:0] A_CHR_BANK0  = 16'h5120;
  localparam logic [15:0] A_IRQ_TARGET = 16'h5203;
  localparam logic [15:0] A_IRQ_STATUS = 16'h5204;
  localparam logic [15:0] A_MUL_LO     = 16'h5205;
  localparam logic [15:0] A_MUL_HI     = 16'h5206;
  localparam logic [15:0] A_EXRAM      = 16'h5C00;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_PRG_ROM_MASK;
  logic [20:0] cfg_data_i = '0;

  cartridge_bank_mapper_with_scanline_irq_unit dut (.*);

  always #HALF_PERIOD clk_i = ~clk_i;

  // mirror of the mapper state
  logic [19:0] rom_mask;
  logic [15:0] ram_mask;
  logic [20:0] pat_mask;
  logic [1:0]  prg_mode, chr_mode, exram_mode;
  logic [2:0]  low_bank;
  logic [7:0]  prg_bank [4];
  logic [7:0]  chr_bank [12];
  logic        upper_last, irq_en, in_frame, pending, irq_out;
  logic [7:0]  mul_a, mul_b, irq_target, line_cnt;
  logic [7:0]  exram [1024];

  out_item_t   expected_results [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;

  function automatic logic [31:0] rom_addr(logic [31:0] bank, logic [31:0] off);
    return ((bank << 13) + off) & {12'd0, rom_mask};
  endfunction

  function automatic logic [31:0] ram_addr(logic [31:0] bank, logic chip, logic [31:0] off);
    return (((bank << 13) + off) & {16'd0, ram_mask}) | (chip ? 32'h8000 : 32'h0);
  endfunction

  function automatic tgt_e map_program(logic [31:0] a, output logic [31:0] ma);
    logic [31:0] b3, slot, clr, off, b;
    b3 = prg_bank[3];
    if (prg_mode == 2'd0) begin
      ma = rom_addr(b3 & 32'h7C, a & 32'h7FFF);
      return TGT_ROM;
    end
    if (prg_mode == 2'd1 && a >= 32'hC000) begin
      ma = rom_addr(b3 & 32'h7E, a & 32'h3FFF);
      return TGT_ROM;
    end
    if (a >= 32'hE000) begin
      ma = rom_addr(b3 & 32'h7F, a & 32'h1FFF);
      return TGT_ROM;
    end
    if (prg_mode != 2'd3 && a < 32'hC000) begin
      slot = 1; clr = 1; off = a & 32'h3FFF;
    end else begin
      slot = (a >> 13) & 32'd3; clr = 0; off = a & 32'h1FFF;
    end
    b = prg_bank[slot];
    if (b[7]) begin
      ma = rom_addr((b & 32'h7F) & ~clr, off);
      return TGT_ROM;
    end
    ma = ram_addr((b & 32'd3) & ~clr, b[2], off);
    return TGT_RAM;
  endfunction

  function automatic logic [31:0] map_pattern(logic [31:0] a, logic [1:0] kind, logic tall);
    logic [31:0] shift, w, off, idx;
    logic        upper;
    shift = 32'd13 - chr_mode;
    w = (a & 32'h1FFF) >> shift;
    off = a & ((32'd1 << shift) - 1);
    upper = tall && (kind == FETCH_BG || (kind == FETCH_PORT && upper_last));
    if (!upper) idx = (w + 1) * (32'd8 >> chr_mode) - 1;
    else if (chr_mode == 2'd3) idx = 8 + (w & 3);
    else if (chr_mode == 2'd2) idx = 9 + 2 * (w & 1);
    else idx = 11;
    return ((32'(chr_bank[idx]) << shift) + off) & {11'd0, pat_mask};
  endfunction

  function automatic void register_write(logic [15:0] a, logic [7:0] v);
    logic [5:0] r;
    r = a[5:0];
    if (a >= 16'h5100 && a < 16'h512C) begin
      if (r == 6'h00) prg_mode = v[1:0];
      else if (r == 6'h01) chr_mode = v[1:0];
      else if (r == 6'h04) exram_mode = v[1:0];
      else if (r == 6'h13) low_bank = v[2:0];
      else if (r >= 6'h14 && r <= 6'h17) prg_bank[r - 6'h14] = v;
      else if (r >= 6'h20 && r <= 6'h2B) begin
        chr_bank[r - 6'h20] = v;
        upper_last = (r >= 6'h28);
      end
    end else if (a >= 16'h5200 && a < 16'h5207) begin
      case (a[2:0])
        3'd3: irq_target = v;
        3'd4: irq_en = v[7];
        3'd5: mul_a = v;
        3'd6: mul_b = v;
        default: ;
      endcase
    end else if (a >= 16'h5C00 && a < 16'h6000) begin
      exram[a[9:0]] = v;
    end
  endfunction

  function automatic logic [7:0] register_read(logic [15:0] a, logic [7:0] bus);
    logic [15:0] prod;
    logic [7:0]  s;
    prod = mul_a * mul_b;
    if (a >= 16'h5200 && a < 16'h5207) begin
      case (a[2:0])
        3'd3: return irq_target;
        3'd4: begin
          s = {pending, in_frame, 6'd0};
          pending = 1'b0;
          irq_out = 1'b0;
          return s;
        end
        3'd5: return prod[7:0];
        3'd6: return prod[15:8];
        default: return bus;
      endcase
    end
    if (a >= 16'h5C00 && a < 16'h6000 && exram_mode >= 2'd2) return exram[a[9:0]];
    return bus;
  endfunction

  function automatic void line_tick(logic frame, logic done);
    if (frame) begin
      if (done) begin
        if (!in_frame) begin
          in_frame = 1'b1;
          line_cnt = 8'd0;
          pending = 1'b0;
        end else begin
          line_cnt = line_cnt + 8'd1;
          if (line_cnt == irq_target) pending = 1'b1;
        end
      end
    end else begin
      in_frame = 1'b0;
    end
    if (pending && irq_en) irq_out = 1'b1;
  endfunction

  function automatic out_item_t translate(in_item_t it);
    out_item_t   r;
    logic [31:0] a, ma;
    tgt_e        t;
    r = '0;
    a = {16'd0, it.address};
    ma = 0;
    case (cmd_e'(it.command))
      CMD_READ: begin
        if (a >= 32'h6000 && a < 32'h8000) begin
          r.target = TGT_RAM;
          ma = ram_addr(low_bank[1:0], low_bank[2], a & 32'h1FFF);
        end else if (a >= 32'h8000) begin
          r.target = map_program(a, ma);
        end else begin
          r.read_data = register_read(it.address, it.bus_value);
        end
      end
      CMD_WRITE: begin
        if (a >= 32'h6000 && a < 32'h8000) begin
          r.target = TGT_RAM;
          r.mem_write = 1'b1;
          ma = ram_addr(low_bank[1:0], low_bank[2], a & 32'h1FFF);
        end else if (a >= 32'h8000) begin
          t = map_program(a, ma);
          if (t == TGT_RAM) begin
            r.target = TGT_RAM;
            r.mem_write = 1'b1;
          end else begin
            ma = 0;
          end
        end else begin
          register_write(it.address, it.write_data);
        end
      end
      CMD_FETCH: begin
        r.target = TGT_CHR;
        ma = map_pattern(a, it.fetch_kind, it.tall_sprites);
      end
      default: line_tick(it.frame_active, it.line_done);
    endcase
    r.mem_address = ma[20:0];
    r.irq = irq_out;
    return r;
  endfunction

  function automatic void mirror_reset();
    rom_mask = 20'hFFFFF; ram_mask = 16'h7FFF; pat_mask = 21'h1FFF;
    prg_mode = 2'd3; chr_mode = 2'd3; exram_mode = 2'd0; low_bank = 3'd0;
    prg_bank = '{8'd0, 8'd0, 8'd0, 8'hFF};
    foreach (chr_bank[i]) chr_bank[i] = 8'd0;
    foreach (exram[i]) exram[i] = 8'd0;
    upper_last = 0; mul_a = 0; mul_b = 0; irq_target = 0; irq_en = 0;
    line_cnt = 0; in_frame = 0; pending = 0; irq_out = 0;
  endfunction

  function automatic in_item_t mk(cmd_e c, logic [15:0] a, logic [7:0] wd = 8'h00,
                                  logic [7:0] bus = 8'h00, logic [1:0] kind = 2'd0,
                                  logic tall = 1'b0, logic fr = 1'b0, logic dn = 1'b0);
    in_item_t it;
    it.command = c; it.address = a; it.write_data = wd; it.bus_value = bus;
    it.fetch_kind = kind; it.tall_sprites = tall; it.frame_active = fr; it.line_done = dn;
    return it;
  endfunction

  function automatic out_item_t res(tgt_e t, logic [20:0] ma, logic [7:0] rd);
    out_item_t r;
    r.target = t; r.mem_address = ma; r.mem_write = 1'b0; r.read_data = rd; r.irq = 1'b0;
    return r;
  endfunction

  function automatic in_item_t random_bus_event();
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom}));
    case ($urandom_range(0, 11))
      0, 1: begin
        it.command = CMD_WRITE;
        it.address = A_PRG_MODE + 16'($urandom_range(0, 16'h2B));
      end
      2: begin
        it.command = 2'($urandom_range(0, 1));
        it.address = 16'h5200 + 16'($urandom_range(0, 7));
        if (it.address == A_IRQ_TARGET) it.write_data = 8'($urandom_range(0, 6));
      end
      3: begin
        it.command = 2'($urandom_range(0, 1));
        it.address = A_EXRAM + 16'($urandom_range(0, 16'h3FF));
      end
      4, 5: begin
        it.command = 2'($urandom_range(0, 1));
        it.address = 16'($urandom_range(16'h6000, 16'hFFFF));
      end
      6, 7: it.command = CMD_FETCH;
      8, 9, 10: begin
        it.command = CMD_TICK;
        it.frame_active = ($urandom_range(0, 15) != 0);
        it.line_done = ($urandom_range(0, 3) != 0);
      end
      default: ;
    endcase
    if (it.command == CMD_FETCH && $urandom_range(0, 3) != 0)
      it.fetch_kind = 2'($urandom_range(0, 2));
    return it;
  endfunction

  // one bus event in, prediction queued at the transfer edge
  task automatic send_event(in_item_t it, logic typed, out_item_t typed_res);
    int        gap;
    out_item_t r;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = translate(it);
    expected_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_mask(logic [1:0] idx, logic [20:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PRG_ROM_MASK: rom_mask = value[19:0];
      CFG_PRG_RAM_MASK: ram_mask = value[15:0];
      CFG_CHR_MASK:     pat_mask = value;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, out_item_t got, out_item_t want);
    mismatches++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // receiver side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int w;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      w = quiet ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data_o, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.target !== want.target) report_mismatch("target", out_data_o, want);
        else if (out_data_o.mem_address !== want.mem_address)
          report_mismatch("mem_address", out_data_o, want);
        else if (out_data_o.mem_write !== want.mem_write)
          report_mismatch("mem_write", out_data_o, want);
        else if (out_data_o.read_data !== want.read_data)
          report_mismatch("read_data", out_data_o, want);
        else if (out_data_o.irq !== want.irq) report_mismatch("irq", out_data_o, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("cartridge_bank_mapper_with_scanline_irq_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  typedef struct {
    in_item_t  it;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  initial begin : stimulus
    dir_row_t    dir_tab [$];
    logic [20:0] rom_set [N_PHASES];
    logic [20:0] ram_set [N_PHASES];
    logic [20:0] pat_set [N_PHASES];
    mirror_reset();
    // reset state: top bank 0x7F mapped at 0xE000
    dir_tab.push_back('{mk(CMD_READ, 16'hE000), 1, res(TGT_ROM, 21'hFE000, 8'h00)});
    dir_tab.push_back('{mk(CMD_READ, A_IRQ_STATUS, 0, 8'h5A), 1, res(TGT_NONE, 0, 8'h00)});
    dir_tab.push_back('{mk(CMD_READ, 16'h5000, 0, 8'hA5), 1, res(TGT_NONE, 0, 8'hA5)});
    dir_tab.push_back('{mk(CMD_WRITE, 16'h8000, 8'hFF), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_PRG_MODE, 8'h00), 1, res(TGT_NONE, 0, 8'h00)});
    dir_tab.push_back('{mk(CMD_READ, 16'hFFFF), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_PRG_MODE, 8'h01), 0, '0});
    dir_tab.push_back('{mk(CMD_READ, 16'hC000), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_PRG_BANK0 + 16'd1, 8'h85), 0, '0});
    dir_tab.push_back('{mk(CMD_READ, 16'h8000), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_PRG_MODE, 8'h02), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, 16'hA000, 8'h11), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_LOW_BANK, 8'hFF), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, 16'h7FFF, 8'h22), 0, '0});
    dir_tab.push_back('{mk(CMD_FETCH, 16'hFFFF, 0, 0, 2'd3, 1'b1), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_CHR_BANK0 + 16'd8, 8'hC3), 0, '0});
    dir_tab.push_back('{mk(CMD_FETCH, 16'h1234, 0, 0, FETCH_PORT, 1'b1), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_CHR_MODE, 8'h00), 0, '0});
    dir_tab.push_back('{mk(CMD_FETCH, 16'h1FFF, 0, 0, FETCH_BG, 1'b1), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_IRQ_TARGET, 8'h02), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_IRQ_STATUS, 8'h80), 0, '0});
    for (int i = 0; i < 3; i++)
      dir_tab.push_back('{mk(CMD_TICK, 0, 0, 0, 0, 0, 1'b1, 1'b1), 0, '0});
    dir_tab.push_back('{mk(CMD_READ, A_IRQ_STATUS), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_MUL_LO, 8'hFF), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_MUL_HI, 8'hFF), 0, '0});
    dir_tab.push_back('{mk(CMD_READ, A_MUL_LO), 1, res(TGT_NONE, 0, 8'h01)});
    dir_tab.push_back('{mk(CMD_READ, A_MUL_HI), 1, res(TGT_NONE, 0, 8'hFE)});
    dir_tab.push_back('{mk(CMD_WRITE, 16'h5FFF, 8'h3C), 0, '0});
    dir_tab.push_back('{mk(CMD_WRITE, A_EXRAM_MODE, 8'h02), 0, '0});
    dir_tab.push_back('{mk(CMD_READ, 16'h5FFF, 0, 8'h77), 1, res(TGT_NONE, 0, 8'h3C)});
    dir_tab.push_back('{mk(CMD_READ, A_EXRAM, 0, 8'h77), 1, res(TGT_NONE, 0, 8'h00)});
    dir_tab.push_back('{mk(CMD_TICK, 0, 0, 0, 0, 0, 1'b0, 1'b1), 0, '0});

    // mask settings per phase: defaults, all ones, zero, random, small
    rom_set = '{21'hFFFFF, 21'hFFFFF, 21'h0, 21'($urandom), 21'h07FFF};
    ram_set = '{21'h7FFF, 21'hFFFF, 21'h0, 21'($urandom), 21'h1FFF};
    pat_set = '{21'h1FFF, 21'h1FFFFF, 21'h0, 21'($urandom), 21'h3FFFF};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_event(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_mask(CFG_PRG_ROM_MASK, rom_set[p]);
      write_mask(CFG_PRG_RAM_MASK, ram_set[p]);
      write_mask(CFG_CHR_MASK, pat_set[p]);
      cfg_valid_i <= 1'b0;
      quiet = (p == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 20) hold_req = 1'b1;
        // sender waits for the block to empty midway through one phase
        if (p == 3 && n == PHASE_ITEMS / 2) drain();
        send_event(random_bus_event(), 1'b0, '0);
      end
      quiet = 1'b0;
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("cartridge_bank_mapper_with_scanline_irq_unit verification clean");
    else
      $display("cartridge_bank_mapper_with_scanline_irq_unit verification failed");
    $finish;
  end

endmodule
